/* src/gmi_pkg.sv */
// Package: types, register map and constants shared by the GPIO controller files.
`default_nettype none

package gmi_pkg;

    localparam int unsigned PIN_COUNT = 8;
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned ADDR_W    = 12;

    // Only the low PIN_COUNT pins exist; everything above reads as zero.
    localparam logic [DATA_W-1:0] PIN_MASK =
        DATA_W'((DATA_W+1)'(1) << PIN_COUNT) - DATA_W'(1);

    // Item kinds
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Register map, byte offsets
    localparam logic [ADDR_W-1:0] OFF_DATA_END = 12'h3FC;
    localparam logic [ADDR_W-1:0] OFF_DIR      = 12'h400;
    localparam logic [ADDR_W-1:0] OFF_SENSE    = 12'h404;
    localparam logic [ADDR_W-1:0] OFF_BOTH     = 12'h408;
    localparam logic [ADDR_W-1:0] OFF_EVENT    = 12'h40C;
    localparam logic [ADDR_W-1:0] OFF_ENABLE   = 12'h410;
    localparam logic [ADDR_W-1:0] OFF_RAW      = 12'h414;
    localparam logic [ADDR_W-1:0] OFF_MASKED   = 12'h418;
    localparam logic [ADDR_W-1:0] OFF_CLEAR    = 12'h41C;
    localparam logic [ADDR_W-1:0] OFF_ALT      = 12'h420;
    localparam logic [ADDR_W-1:0] OFF_ID0      = 12'hFE0;
    localparam logic [ADDR_W-1:0] OFF_ID1      = 12'hFE4;

    localparam logic [DATA_W-1:0] ID_BYTE0 = 8'h61;
    localparam logic [DATA_W-1:0] ID_BYTE1 = 8'h10;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] pin_levels;
    } item_t;

    typedef struct packed {
        logic              interrupt;
        logic [DATA_W-1:0] masked_status;
        logic [DATA_W-1:0] alt_function;
        logic [DATA_W-1:0] pin_enable;
        logic [DATA_W-1:0] pin_drive;
        logic [DATA_W-1:0] read_data;
    } result_t;

endpackage

`default_nettype wire

/* src/gmi_core.sv */
// Register file, bus decode and interrupt detection of the GPIO controller.
`default_nettype none

module gmi_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire gmi_pkg::item_t  item,
    output gmi_pkg::result_t     result
);

    logic [gmi_pkg::DATA_W-1:0] out_value_reg,   out_value_next;
    logic [gmi_pkg::DATA_W-1:0] direction_reg,   direction_next;
    logic [gmi_pkg::DATA_W-1:0] alt_select_reg,  alt_select_next;
    logic [gmi_pkg::DATA_W-1:0] sense_level_reg, sense_level_next;
    logic [gmi_pkg::DATA_W-1:0] both_edges_reg,  both_edges_next;
    logic [gmi_pkg::DATA_W-1:0] event_high_reg,  event_high_next;
    logic [gmi_pkg::DATA_W-1:0] irq_enable_reg,  irq_enable_next;
    logic [gmi_pkg::DATA_W-1:0] raw_status_reg,  raw_status_next;
    logic [gmi_pkg::DATA_W-1:0] prev_levels_reg;

    logic [gmi_pkg::ADDR_W-1:0] off;
    logic [gmi_pkg::DATA_W-1:0] wd, pins, sel, rd, clr;
    logic [gmi_pkg::DATA_W-1:0] rise, fall, edge_hit, level_hit, ms;
    logic                       in_data;

    assign off     = {item.address[gmi_pkg::ADDR_W-1:2], 2'b00};
    assign in_data = (off <= gmi_pkg::OFF_DATA_END);
    assign wd      = item.write_data & gmi_pkg::PIN_MASK;
    assign pins    = item.pin_levels & gmi_pkg::PIN_MASK;
    assign sel     = item.address[9:2] & gmi_pkg::PIN_MASK;

    // Bus access: reads see the state before this item
    always_comb begin
        rd               = '0;
        clr              = '0;
        out_value_next   = out_value_reg;
        direction_next   = direction_reg;
        alt_select_next  = alt_select_reg;
        sense_level_next = sense_level_reg;
        both_edges_next  = both_edges_reg;
        event_high_next  = event_high_reg;
        irq_enable_next  = irq_enable_reg;
        unique case (item.command)
            gmi_pkg::CMD_READ: begin
                if (in_data) begin
                    rd = ((pins & ~direction_reg) | (out_value_reg & direction_reg)) & sel;
                end else begin
                    unique case (off)
                        gmi_pkg::OFF_DIR:    rd = direction_reg;
                        gmi_pkg::OFF_SENSE:  rd = sense_level_reg;
                        gmi_pkg::OFF_BOTH:   rd = both_edges_reg;
                        gmi_pkg::OFF_EVENT:  rd = event_high_reg;
                        gmi_pkg::OFF_ENABLE: rd = irq_enable_reg;
                        gmi_pkg::OFF_RAW:    rd = raw_status_reg;
                        gmi_pkg::OFF_MASKED: rd = raw_status_reg & irq_enable_reg;
                        gmi_pkg::OFF_ALT:    rd = alt_select_reg;
                        gmi_pkg::OFF_ID0:    rd = gmi_pkg::ID_BYTE0;
                        gmi_pkg::OFF_ID1:    rd = gmi_pkg::ID_BYTE1;
                        default:             rd = '0;
                    endcase
                end
            end
            gmi_pkg::CMD_WRITE: begin
                if (in_data) begin
                    // only output pins picked by the address mask change
                    out_value_next = (out_value_reg & ~(sel & direction_reg))
                                   | (wd & sel & direction_reg);
                end else begin
                    unique case (off)
                        gmi_pkg::OFF_DIR:    direction_next   = wd;
                        gmi_pkg::OFF_SENSE:  sense_level_next = wd;
                        gmi_pkg::OFF_BOTH:   both_edges_next  = wd;
                        gmi_pkg::OFF_EVENT:  event_high_next  = wd;
                        gmi_pkg::OFF_ENABLE: irq_enable_next  = wd;
                        gmi_pkg::OFF_CLEAR:  clr              = wd;
                        gmi_pkg::OFF_ALT:    alt_select_next  = wd;
                        default:             clr              = '0;
                    endcase
                end
            end
            default: rd = '0;   // tick or unknown kind
        endcase
    end

    // Interrupt detection with the configuration after the access
    always_comb begin
        rise      = pins & ~prev_levels_reg;
        fall      = ~pins & prev_levels_reg;
        edge_hit  = ((both_edges_next & (rise | fall))
                  | (~both_edges_next & event_high_next & rise)
                  | (~both_edges_next & ~event_high_next & fall)) & ~sense_level_next;
        level_hit = sense_level_next & ~(pins ^ event_high_next);
        // clear first, so an edge in the same beat stays latched
        raw_status_next = ((((raw_status_reg & ~clr) | edge_hit) & ~sense_level_next)
                        | level_hit) & gmi_pkg::PIN_MASK;
        ms = raw_status_next & irq_enable_next & gmi_pkg::PIN_MASK;
    end

    always_comb begin
        result.read_data     = rd;
        result.pin_drive     = out_value_next;
        result.pin_enable    = direction_next & ~alt_select_next;
        result.alt_function  = alt_select_next;
        result.masked_status = ms;
        result.interrupt     = |ms;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_value_reg   <= '0;
            direction_reg   <= '0;
            alt_select_reg  <= '0;
            sense_level_reg <= '0;
            both_edges_reg  <= '0;
            event_high_reg  <= '0;
            irq_enable_reg  <= '0;
            raw_status_reg  <= '0;
            prev_levels_reg <= '0;
        end else if (en) begin
            out_value_reg   <= out_value_next;
            direction_reg   <= direction_next;
            alt_select_reg  <= alt_select_next;
            sense_level_reg <= sense_level_next;
            both_edges_reg  <= both_edges_next;
            event_high_reg  <= event_high_next;
            irq_enable_reg  <= irq_enable_next;
            raw_status_reg  <= raw_status_next;
            prev_levels_reg <= pins;
        end
    end

`ifndef ASSERT_OFF
    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(raw_status_reg) && $stable(prev_levels_reg)
                 && $stable(out_value_reg)))
        else $error("state moved without a beat");

    a_drive_only_data_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && !(item.command == gmi_pkg::CMD_WRITE && in_data)) |=> $stable(out_value_reg))
        else $error("output value changed outside a data write");

    a_dir_only_dir_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && !(item.command == gmi_pkg::CMD_WRITE && off == gmi_pkg::OFF_DIR))
        |=> $stable(direction_reg))
        else $error("direction changed outside its write");

    a_level_follows_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        en |=> ((raw_status_reg & sense_level_reg) == $past(level_hit)))
        else $error("level status does not follow pin");
`endif

endmodule

`default_nettype wire

/* src/gpio_controller_masked_irq.sv */
// Top level: stream wrapper with input and result registers around the GPIO core.
// Path: input register, then result register. Throughput: one beat per cycle while the
// result is not stalled; the core's per-pin logic settles between the two registers.
// A stalled result holds; a new beat is still taken while the input register can move on.
// Reset (aresetn low, synchronous): all GPIO registers, raw status and the previous
// pin sample clear to zero, so the first sample high after reset counts as a rising edge.
`default_nettype none

module gpio_controller_masked_irq (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // address[11:0], write_data[19:12], pin_levels[27:20]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // read_data[7:0], pin_drive[15:8], pin_enable[23:16],
                                        // alt_function[31:24], masked_status[39:32],
                                        // interrupt[40]
);

    logic             in_valid_reg;
    gmi_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    gmi_pkg::result_t out_result_reg;
    gmi_pkg::result_t core_result;
    logic             advance;

    // the held beat moves into the result register when that is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.command    <= s_tuser;
            in_item_reg.address    <= s_tdata[11:0];
            in_item_reg.write_data <= s_tdata[19:12];
            in_item_reg.pin_levels <= s_tdata[27:20];
        end
    end

    // state updates exactly once per beat, when it passes to the result register
    gmi_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_result_reg};

endmodule

`default_nettype wire
